/* src/dsrm_pkg.sv */
// dsrm_pkg: shared types and constants for the sun shadow ray march block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package dsrm_pkg;

   localparam int DEF_MAX_COLS    = 512;
   localparam int DEF_MAX_ROWS    = 512;
   localparam int DEF_HEIGHT_BITS = 24;

   localparam int OP_W    = 1;
   localparam int COORD_W = 10;
   localparam int ELEV_W  = 24;
   localparam int CSR_W   = 20;
   localparam int CIDX_W  = 3;

   localparam int POS_FRAC = 16;
   localparam int POS_HALF = 32768;

   // ratio divider: 34-bit dividend, 17-bit divisor, 17-bit quotient
   localparam int DIV_NUM_W = 34;
   localparam int DIV_DEN_W = 17;
   localparam int DIV_Q_W   = 17;
   localparam int DIV_CNT_W = 5;

   localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
   localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

   localparam logic [CIDX_W-1:0] CFG_GRID_COLS = 3'd0;
   localparam logic [CIDX_W-1:0] CFG_GRID_ROWS = 3'd1;
   localparam logic [CIDX_W-1:0] CFG_SUN_X     = 3'd2;
   localparam logic [CIDX_W-1:0] CFG_SUN_Y     = 3'd3;
   localparam logic [CIDX_W-1:0] CFG_SUN_Z     = 3'd4;
   localparam logic [CIDX_W-1:0] CFG_CELL_SIZE = 3'd5;

   localparam logic [9:0]  RST_GRID_COLS = 10'd512;
   localparam logic [9:0]  RST_GRID_ROWS = 10'd512;
   localparam logic [15:0] RST_SUN_X     = 16'd0;
   localparam logic [15:0] RST_SUN_Y     = 16'd0;
   localparam logic [15:0] RST_SUN_Z     = 16'd32767;
   localparam logic [19:0] RST_CELL_SIZE = 20'd2500;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage
`default_nettype wire

/* src/dsrm_mem.sv */
// dsrm_mem: elevation store, one write port and one registered read port
// depends on nothing but its parameters
`timescale 1ns / 1ps
`default_nettype none
module dsrm_mem #(
   parameter int DEPTH = 262144,
   parameter int DW    = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DW-1:0]            wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DW-1:0]            rd_data
);
   logic [DW-1:0] store_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* src/dsrm_div.sv */
// dsrm_div: restoring divider, one quotient bit per cycle
// depends on dsrm_pkg
`timescale 1ns / 1ps
`default_nettype none
module dsrm_div (
   input  logic                             clock,
   input  logic                             reset,
   input  dsrm_pkg::div_ctl_type            ctl,
   input  logic [dsrm_pkg::DIV_NUM_W-1:0]   num,
   input  logic [dsrm_pkg::DIV_DEN_W-1:0]   den,
   output dsrm_pkg::div_sts_type            sts,
   output logic [dsrm_pkg::DIV_Q_W-1:0]     quo
);
   import dsrm_pkg::*;

   logic [DIV_DEN_W:0]   rem_ff, rem_in;
   logic [DIV_Q_W-1:0]   low_ff, low_in;
   logic [DIV_Q_W-1:0]   quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   always_comb begin
      trial  = {rem_ff[DIV_DEN_W-1:0], low_ff[DIV_Q_W-1]};
      fits   = trial >= {1'b0, den_ff};
      rem_in = rem_ff;
      low_in = low_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         // high half is already below the divisor
         rem_in  = {1'b0, num[DIV_NUM_W-1:DIV_Q_W]};
         low_in  = num[DIV_Q_W-1:0];
         den_in  = den;
         cnt_in  = DIV_CNT_W'(DIV_Q_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial - {1'b0, den_ff} : trial;
         low_in = {low_ff[DIV_Q_W-2:0], 1'b0};
         quo_in = {quo_ff[DIV_Q_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quo      = quo_ff;
endmodule
`default_nettype wire

/* src/dem_sun_shadow_ray_march.sv */
// dem_sun_shadow_ray_march: shadow ray march top, uses dsrm_pkg, dsrm_div and dsrm_mem
// writes: the block stays idle and is ready again in the next cycle
// queries outside the grid or with zenith sun: no division or march, straight to S_DONE
// other queries: two ratio divisions, one multiply and the origin read, then ray steps
// through S_ADV, S_CHK, S_RD and S_CMP, up to MAX_COLS+MAX_ROWS+2 steps set by the march length
// synchronous active-high reset clears control state and loads register defaults
`timescale 1ns / 1ps
`default_nettype none
module dem_sun_shadow_ray_march #(
   parameter int MAX_COLS    = dsrm_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS    = dsrm_pkg::DEF_MAX_ROWS,
   parameter int HEIGHT_BITS = dsrm_pkg::DEF_HEIGHT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dsrm_pkg::OP_W-1:0]     req_operation,
   input  logic [dsrm_pkg::COORD_W-1:0]  req_column,
   input  logic [dsrm_pkg::COORD_W-1:0]  req_row,
   input  logic signed [dsrm_pkg::ELEV_W-1:0] req_elevation,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_shaded,
   output logic                          rsp_cell_outside,
   input  logic                          csr_we,
   input  logic [dsrm_pkg::CIDX_W-1:0]   csr_index,
   input  logic [dsrm_pkg::CSR_W-1:0]    csr_wdata
);
   import dsrm_pkg::*;

   localparam int HB    = HEIGHT_BITS;
   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int MAXD  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
   localparam int IXW   = $clog2(MAXD + 3) + 1;
   localparam int PXW   = IXW + POS_FRAC;
   localparam int SZW   = ($clog2(MAXD + 1) > COORD_W) ? $clog2(MAXD + 1) : COORD_W;
   localparam int CMPW  = (IXW > SZW) ? IXW : SZW;
   localparam int MAW   = (HB + 1 > 21) ? HB + 1 : 21;
   localparam int PW    = MAW + 17;
   localparam int KMAX  = MAX_COLS + MAX_ROWS + 2;
   localparam int KW    = $clog2(KMAX + 1);
   localparam int ACCW  = PW + KW;
   localparam int CW    = ACCW + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_DIVX, S_DIVY, S_MULDS, S_ORIG, S_H0,
      S_ADV, S_CHK, S_RD, S_CMP, S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [9:0]         grid_cols_ff, grid_rows_ff;
   logic signed [15:0] sun_x_ff, sun_y_ff, sun_z_ff;
   logic [19:0]        cell_size_ff;

   logic signed [PXW-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [17:0]    tx_ff, tx_in, ty_ff, ty_in;
   logic [KW-1:0]         k_ff, k_in;
   logic signed [PW-1:0]  ds_ff, ds_in, prod_ff;
   logic signed [ACCW-1:0] kds_ff, kds_in;
   logic signed [HB-1:0]  h0_ff, h0_in;
   logic [AW-1:0]         orig_ff, orig_in;
   logic                  res_shaded_ff, res_shaded_in, res_out_ff, res_out_in;
   logic                  rsp_valid_ff, rsp_valid_in, rsp_shaded_ff, rsp_shaded_in;
   logic                  rsp_out_ff, rsp_out_in;

   logic [SZW-1:0] cols_eff, rows_eff;
   logic           req_inside, accept;
   logic [15:0]    ax, ay, maxc;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_Q_W-1:0]   quo;
   div_ctl_type    div_ctl;
   div_sts_type    div_sts;
   logic signed [17:0] qs;

   logic [AW-1:0]  req_addr, step_addr, rd_addr;
   logic [HB-1:0]  rd_data;
   logic signed [31:0] elev_ext;
   logic           wr_en;

   logic signed [PXW-1:0] pxr, pyr;
   logic [IXW-1:0] ix, iy;
   logic           step_inside;

   logic signed [HB:0]    diff;
   logic signed [MAW-1:0] mul_a;
   logic signed [16:0]    mul_b;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= RST_GRID_COLS;
         grid_rows_ff <= RST_GRID_ROWS;
         sun_x_ff     <= RST_SUN_X;
         sun_y_ff     <= RST_SUN_Y;
         sun_z_ff     <= RST_SUN_Z;
         cell_size_ff <= RST_CELL_SIZE;
      end else if (csr_we) begin
         case (csr_index)
            CFG_GRID_COLS: grid_cols_ff <= csr_wdata[9:0];
            CFG_GRID_ROWS: grid_rows_ff <= csr_wdata[9:0];
            CFG_SUN_X:     sun_x_ff     <= csr_wdata[15:0];
            CFG_SUN_Y:     sun_y_ff     <= csr_wdata[15:0];
            CFG_SUN_Z:     sun_z_ff     <= csr_wdata[15:0];
            CFG_CELL_SIZE: cell_size_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cols_eff = (SZW'(grid_cols_ff) > SZW'(MAX_COLS)) ? SZW'(MAX_COLS)
                                                           : SZW'(grid_cols_ff);
   assign rows_eff = (SZW'(grid_rows_ff) > SZW'(MAX_ROWS)) ? SZW'(MAX_ROWS)
                                                           : SZW'(grid_rows_ff);

   assign ax   = sun_x_ff[15] ? 16'(~sun_x_ff + 16'sd1) : 16'(sun_x_ff);
   assign ay   = sun_y_ff[15] ? 16'(~sun_y_ff + 16'sd1) : 16'(sun_y_ff);
   assign maxc = (ax > ay) ? ax : ay;

   // ---------------- request decode ----------------
   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign req_inside = (req_column != '0) && (SZW'(req_column) <= cols_eff) &&
                       (req_row != '0) && (SZW'(req_row) <= rows_eff);
   assign req_addr   = AW'(req_row - 1'b1) * AW'(MAX_COLS) + AW'(req_column - 1'b1);
   assign elev_ext   = 32'(req_elevation);
   assign wr_en      = accept && (req_operation == OP_WRITE) && req_inside;

   // ---------------- ratio divider ----------------
   // |s|*2^17 + maxc over 2*maxc gives the step ratio rounded half away from zero
   assign div_num = (state_ff == S_IDLE) ? DIV_NUM_W'({ax, 17'b0}) + DIV_NUM_W'(maxc)
                                         : DIV_NUM_W'({ay, 17'b0}) + DIV_NUM_W'(maxc);
   assign div_ctl.start = (accept && (req_operation == OP_QUERY) && req_inside &&
                           (maxc != '0)) ||
                          ((state_ff == S_DIVX) && div_sts.done);

   dsrm_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (div_num),
      .den   ({maxc, 1'b0}),
      .sts   (div_sts),
      .quo   (quo)
   );

   assign qs = $signed(18'(quo));

   // ---------------- height store ----------------
   dsrm_mem #(
      .DEPTH (DEPTH),
      .DW    (HB)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_addr),
      .wr_data (elev_ext[HB-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------- ray position ----------------
   assign pxr = px_ff + PXW'(POS_HALF);
   assign pyr = py_ff + PXW'(POS_HALF);
   assign ix  = pxr[PXW-1:POS_FRAC];
   assign iy  = pyr[PXW-1:POS_FRAC];
   // a negative position always rounds to column or row zero or below
   assign step_inside = !px_ff[PXW-1] && !py_ff[PXW-1] && (ix != '0) && (iy != '0) &&
                        (CMPW'(ix) <= CMPW'(cols_eff)) && (CMPW'(iy) <= CMPW'(rows_eff));
   assign step_addr = AW'(iy - 1'b1) * AW'(MAX_COLS) + AW'(ix - 1'b1);
   assign rd_addr   = (state_ff == S_ORIG) ? orig_ff : step_addr;

   // ---------------- shared multiplier ----------------
   assign diff = (HB+1)'($signed(rd_data)) - (HB+1)'(h0_ff);

   always_comb begin
      if (state_ff == S_MULDS) begin
         mul_a = MAW'($signed({1'b0, cell_size_ff}));
         mul_b = 17'(sun_z_ff);
      end else begin
         mul_a = MAW'(diff);
         mul_b = $signed({1'b0, maxc});
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PW'(mul_a) * PW'(mul_b);
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in      = state_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      tx_in         = tx_ff;
      ty_in         = ty_ff;
      k_in          = k_ff;
      ds_in         = ds_ff;
      kds_in        = kds_ff;
      h0_in         = h0_ff;
      orig_in       = orig_ff;
      res_shaded_in = res_shaded_ff;
      res_out_in    = res_out_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_shaded_in = rsp_shaded_ff;
      rsp_out_in    = rsp_out_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_operation == OP_QUERY)) begin
               px_in         = PXW'({IXW'(req_column), 16'b0});
               py_in         = PXW'({IXW'(req_row), 16'b0});
               orig_in       = req_addr;
               res_shaded_in = 1'b0;
               res_out_in    = !req_inside;
               state_in      = (req_inside && (maxc != '0)) ? S_DIVX : S_DONE;
            end
         end
         S_DIVX: begin
            if (div_sts.done) begin
               tx_in    = sun_x_ff[15] ? -qs : qs;
               state_in = S_DIVY;
            end
         end
         S_DIVY: begin
            if (div_sts.done) begin
               ty_in    = sun_y_ff[15] ? -qs : qs;
               state_in = S_MULDS;
            end
         end
         S_MULDS: begin
            state_in = S_ORIG;
         end
         S_ORIG: begin
            ds_in    = prod_ff;
            state_in = S_H0;
         end
         S_H0: begin
            h0_in    = $signed(rd_data);
            k_in     = '0;
            kds_in   = '0;
            state_in = S_ADV;
         end
         S_ADV: begin
            px_in    = px_ff + PXW'(tx_ff);
            py_in    = py_ff + PXW'(ty_ff);
            k_in     = k_ff + 1'b1;
            kds_in   = kds_ff + ACCW'(ds_ff);
            state_in = S_CHK;
         end
         S_CHK: begin
            state_in = step_inside ? S_RD : S_DONE;
         end
         S_RD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (CW'(prod_ff) > CW'(kds_ff)) begin
               res_shaded_in = 1'b1;
               state_in      = S_DONE;
            end else if (k_ff == KW'(KMAX)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_ADV;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_shaded_in = res_shaded_ff;
               rsp_out_in    = res_out_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff         <= px_in;
      py_ff         <= py_in;
      tx_ff         <= tx_in;
      ty_ff         <= ty_in;
      k_ff          <= k_in;
      ds_ff         <= ds_in;
      kds_ff        <= kds_in;
      h0_ff         <= h0_in;
      orig_ff       <= orig_in;
      res_shaded_ff <= res_shaded_in;
      res_out_ff    <= res_out_in;
      rsp_shaded_ff <= rsp_shaded_in;
      rsp_out_ff    <= rsp_out_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_shaded       = rsp_shaded_ff;
   assign rsp_cell_outside = rsp_out_ff;
endmodule
`default_nettype wire

/* src/dsrm_checker.sv */
// dsrm_checker: port-level checks for the sun shadow ray march block
// depends on dsrm_pkg; bound to dem_sun_shadow_ray_march below
`timescale 1ns / 1ps
`default_nettype none
module dsrm_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic [dsrm_pkg::OP_W-1:0]    req_operation,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic                         rsp_shaded,
   input wire logic                         rsp_cell_outside
);
   import dsrm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_shaded) &&
                                  $stable(rsp_cell_outside))
      else $error("result beat changed while stalled");

   a_outside_lit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_shaded && rsp_cell_outside))
      else $error("cell outside grid reported as shaded");

   // first cycle out of reset shows no result
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result beat present right after reset");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == OP_WRITE) && !rsp_valid |=> !rsp_valid)
      else $error("write beat produced a result");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == OP_QUERY) |=> !req_ready)
      else $error("ready stayed high after a query beat");
endmodule

bind dem_sun_shadow_ray_march dsrm_checker u_dsrm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_operation    (req_operation),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_shaded       (rsp_shaded),
   .rsp_cell_outside (rsp_cell_outside)
);
`default_nettype wire

/* dv/shadow_checker.sv */
// shadow_checker: watches the request, result and register ports of the shadow ray march
// block, predicts the shaded and outside flags of every query and compares them
// depends on dsrm_pkg
`timescale 1ns / 1ps
module shadow_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [dsrm_pkg::OP_W-1:0]            req_operation,
   input  logic [dsrm_pkg::COORD_W-1:0]         req_column,
   input  logic [dsrm_pkg::COORD_W-1:0]         req_row,
   input  logic signed [dsrm_pkg::ELEV_W-1:0]   req_elevation,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic                                 rsp_shaded,
   input  logic                                 rsp_cell_outside,
   input  logic                                 csr_we,
   input  logic [dsrm_pkg::CIDX_W-1:0]          csr_index,
   input  logic [dsrm_pkg::CSR_W-1:0]           csr_wdata,
   output int                                   fail_count,
   output int                                   pending
);
   import dsrm_pkg::*;

   localparam int NCOLS = DEF_MAX_COLS;
   localparam int NROWS = DEF_MAX_ROWS;

   typedef struct packed {
      logic shaded;
      logic outside;
   } shadow_flags_type;

   logic signed [DEF_HEIGHT_BITS-1:0] height_mem [0:NCOLS*NROWS-1];
   logic [9:0]         grid_cols, grid_rows;
   logic signed [15:0] sun_x, sun_y, sun_z;
   logic [19:0]        cell_size;
   shadow_flags_type   flags_q [$];

   function automatic longint round_cell(longint p);
      if (p >= 0) return (p + POS_HALF) >>> POS_FRAC;
      return -((-p + POS_HALF) >>> POS_FRAC);
   endfunction

   function automatic longint step_q16(longint s, longint maxc);
      longint a, q;
      a = (s < 0) ? -s : s;
      q = (2 * a * 65536 + maxc) / (2 * maxc);
      return (s < 0) ? -q : q;
   endfunction

   function automatic shadow_flags_type march_shadow(longint col, longint row);
      shadow_flags_type r;
      longint cols, rows, sx, sy, sz, ax, ay, maxc, tx, ty, px, py, h0, h, ix, iy;
      r = '0;
      cols = (grid_cols > NCOLS) ? NCOLS : grid_cols;
      rows = (grid_rows > NROWS) ? NROWS : grid_rows;
      if (col < 1 || col > cols || row < 1 || row > rows) begin
         r.outside = 1'b1;
         return r;
      end
      sx = sun_x;
      sy = sun_y;
      sz = sun_z;
      ax = (sx < 0) ? -sx : sx;
      ay = (sy < 0) ? -sy : sy;
      maxc = (ax > ay) ? ax : ay;
      // sun straight overhead: nothing can occlude
      if (maxc == 0) return r;
      tx = step_q16(sx, maxc);
      ty = step_q16(sy, maxc);
      px = col * 65536;
      py = row * 65536;
      h0 = height_mem[(row - 1) * NCOLS + (col - 1)];
      for (longint k = 1; k <= NCOLS + NROWS + 2; k++) begin
         px += tx;
         py += ty;
         ix = round_cell(px);
         iy = round_cell(py);
         if (ix < 1 || ix > cols || iy < 1 || iy > rows) break;
         h = height_mem[(iy - 1) * NCOLS + (ix - 1)];
         if ((h - h0) * maxc > k * longint'(cell_size) * sz) begin
            r.shaded = 1'b1;
            break;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      shadow_flags_type want;
      longint cols, rows;
      if (reset) begin
         grid_cols = RST_GRID_COLS;
         grid_rows = RST_GRID_ROWS;
         sun_x = RST_SUN_X;
         sun_y = RST_SUN_Y;
         sun_z = RST_SUN_Z;
         cell_size = RST_CELL_SIZE;
         flags_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CFG_GRID_COLS: grid_cols = csr_wdata[9:0];
               CFG_GRID_ROWS: grid_rows = csr_wdata[9:0];
               CFG_SUN_X:     sun_x = csr_wdata[15:0];
               CFG_SUN_Y:     sun_y = csr_wdata[15:0];
               CFG_SUN_Z:     sun_z = csr_wdata[15:0];
               CFG_CELL_SIZE: cell_size = csr_wdata[19:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_operation == OP_QUERY) begin
               flags_q.push_back(march_shadow(req_column, req_row));
            end else begin
               cols = (grid_cols > NCOLS) ? NCOLS : grid_cols;
               rows = (grid_rows > NROWS) ? NROWS : grid_rows;
               if (req_column >= 1 && req_column <= cols && req_row >= 1 && req_row <= rows)
                  height_mem[(req_row - 1) * NCOLS + (req_column - 1)] = req_elevation;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (flags_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("shadow_checker: result beat with no query waiting");
            end else begin
               want = flags_q.pop_front();
               if (want.shaded !== rsp_shaded || want.outside !== rsp_cell_outside) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("shadow_checker: expected shaded=%0d outside=%0d, got %b %b",
                              want.shaded, want.outside, rsp_shaded, rsp_cell_outside);
               end
            end
         end
      end
      pending = flags_q.size();
   end

endmodule

/* dv/tb_top.sv */
// tb_top: drives height writes, shadow queries and register phases into the ray march block
// depends on dsrm_pkg, dem_sun_shadow_ray_march and shadow_checker
`timescale 1ns / 1ps
module tb_top;
   import dsrm_pkg::*;

   localparam int FILL = 24;          // every cell of this corner is written before any query
   localparam int STALL_LIMIT = 40000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OP_W-1:0] req_operation = OP_WRITE;
   logic [COORD_W-1:0] req_column = '0;
   logic [COORD_W-1:0] req_row = '0;
   logic signed [ELEV_W-1:0] req_elevation = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_shaded, rsp_cell_outside;
   logic csr_we = 1'b0;
   logic [CIDX_W-1:0] csr_index = CFG_GRID_COLS;
   logic [CSR_W-1:0] csr_wdata = '0;
   int fail_count, pending;
   int idle_cycles = 0;
   bit req_quiet = 0, rsp_quiet = 0;
   int cur_cols, cur_rows;

   dem_sun_shadow_ray_march dut (.*);

   shadow_checker chk (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // no beat on either side for too long means the block hung
   always @(posedge clock) begin
      if (req_valid && req_ready || rsp_valid && rsp_ready) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 40) == 0) rsp_quiet = !rsp_quiet;
         n = rsp_quiet ? 0 : $urandom_range(0, 18);
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   task automatic send(logic [OP_W-1:0] op, int col, int row, logic [ELEV_W-1:0] elev);
      int n;
      if ($urandom_range(0, 40) == 0) req_quiet = !req_quiet;
      n = req_quiet ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_operation <= op;
      req_column <= col[COORD_W-1:0];
      req_row <= row[COORD_W-1:0];
      req_elevation <= elev;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      // writes leave no result, give the block time to settle
      repeat (60) @(negedge clock);
   endtask

   task automatic load_regs(int cols, int rows, int sx, int sy, int sz, int cs);
      drain();
      cur_cols = cols;
      cur_rows = rows;
      csr_we <= 1'b1;
      csr_index <= CFG_GRID_COLS; csr_wdata <= CSR_W'(cols); @(negedge clock);
      csr_index <= CFG_GRID_ROWS; csr_wdata <= CSR_W'(rows); @(negedge clock);
      csr_index <= CFG_SUN_X; csr_wdata <= CSR_W'(sx & 16'hFFFF); @(negedge clock);
      csr_index <= CFG_SUN_Y; csr_wdata <= CSR_W'(sy & 16'hFFFF); @(negedge clock);
      csr_index <= CFG_SUN_Z; csr_wdata <= CSR_W'(sz & 16'hFFFF); @(negedge clock);
      csr_index <= CFG_CELL_SIZE; csr_wdata <= CSR_W'(cs); @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic int pick_sun();
      case ($urandom_range(0, 5))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return $urandom_range(0, 400) - 200;
         default: return $urandom_range(0, 65535) - 32768;
      endcase
   endfunction

   function automatic logic [ELEV_W-1:0] pick_height();
      case ($urandom_range(0, 4))
         0: return ELEV_W'($urandom());
         1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         default: return ELEV_W'($urandom_range(0, 40000) - 20000);
      endcase
   endfunction

   function automatic int pick_coord(int lim);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
      return $urandom_range(0, lim + 1);
   endfunction

   initial begin
      int sx, sy, cols, rows, cs;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      cur_cols = 512;
      cur_rows = 512;

      // fill the corner used by every marching phase
      for (int r = 1; r <= FILL; r++)
         for (int c = 1; c <= FILL; c++)
            send(OP_WRITE, c, r, pick_height());

      // reset sun is overhead: lit everywhere on the full grid
      send(OP_QUERY, 1, 1, 24'h0);
      send(OP_QUERY, 512, 512, 24'hFFFFFF);
      send(OP_QUERY, 513, 1, 24'h0);
      send(OP_QUERY, 0, 0, 24'h0);

      load_regs(FILL, FILL, 32767, 0, 1000, 1);
      send(OP_WRITE, 1, 1, 24'h800000);
      send(OP_WRITE, FILL, 1, 24'h7FFFFF);
      send(OP_WRITE, 0, 3, 24'h7FFFFF);                 // ignored, column zero
      send(OP_WRITE, FILL + 1, 3, 24'h7FFFFF);          // ignored, past the grid
      send(OP_QUERY, 1, 1, 24'h0);
      send(OP_QUERY, FILL, FILL, 24'h0);
      send(OP_QUERY, 1, 0, 24'h0);
      send(OP_QUERY, 1023, 1023, 24'h0);

      load_regs(FILL, FILL, -32768, -32768, -32768, 0); // negative sun_z, zero cell size
      send(OP_QUERY, FILL, FILL, 24'h0);
      send(OP_QUERY, 5, 7, 24'h0);

      load_regs(7, 3, 12345, -30000, 32767, 1048575);   // shrink after writes
      send(OP_QUERY, 7, 3, 24'h0);
      send(OP_QUERY, 8, 3, 24'h0);

      load_regs(0, 0, 100, 100, 1, 2500);               // empty grid
      send(OP_QUERY, 1, 1, 24'h0);
      send(OP_WRITE, 1, 1, 24'h123456);

      load_regs(1023, 1023, 0, 0, 0, 1);                // oversize grid, zenith sun
      send(OP_QUERY, 512, 512, 24'h0);
      send(OP_QUERY, 600, 2, 24'h0);

      for (int ph = 0; ph < 20; ph++) begin
         if ($urandom_range(0, 5) == 0) begin
            // large grids only with the sun overhead so unwritten cells are never read
            case ($urandom_range(0, 3))
               0: cols = 512;
               1: cols = 1023;
               2: cols = 0;
               default: cols = $urandom_range(1, 1023);
            endcase
            rows = $urandom_range(0, 1023);
            sx = 0;
            sy = 0;
         end else begin
            cols = $urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, FILL);
            rows = $urandom_range(0, 3) == 0 ? FILL : $urandom_range(1, FILL);
            sx = pick_sun();
            sy = pick_sun();
         end
         case ($urandom_range(0, 3))
            0: cs = 0;
            1: cs = 1048575;
            2: cs = $urandom_range(1, 100);
            default: cs = $urandom_range(0, 1048575);
         endcase
         load_regs(cols, rows, sx, sy, pick_sun(), cs);
         for (int i = 0; i < 20; i++) begin
            if ($urandom_range(0, 9) < 4)
               send(OP_WRITE, pick_coord(cur_cols > FILL ? FILL : cur_cols),
                    pick_coord(cur_rows > FILL ? FILL : cur_rows), pick_height());
            else
               send(OP_QUERY, pick_coord(cur_cols > FILL ? FILL : cur_cols),
                    pick_coord(cur_rows > FILL ? FILL : cur_rows), ELEV_W'($urandom()));
         end
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
